@@ src/scba_pkg.sv @@
// package: constants, types and class table for the size class block allocator
`timescale 1ns / 1ps
package scba_pkg;
   localparam int NUM_CHUNKS  = 64;
   localparam int CHUNK_BYTES = 16384;
   localparam int CLASS_COUNT = 14;
   localparam int MAX_BLOCK   = 640;
   localparam int ADDR_W      = 20;
   localparam int SLOT_W      = 16;
   localparam int CLASS_W     = 4;
   localparam int CHUNK_W     = $clog2(NUM_CHUNKS + 1);
   localparam int BSIZE_W     = 10;
   localparam int QDEPTH      = 2;

   // offset of the last whole block of a chunk, per class
   localparam logic [ADDR_W-1:0] LAST_16  = ADDR_W'((CHUNK_BYTES / 16 - 1) * 16);
   localparam logic [ADDR_W-1:0] LAST_32  = ADDR_W'((CHUNK_BYTES / 32 - 1) * 32);
   localparam logic [ADDR_W-1:0] LAST_64  = ADDR_W'((CHUNK_BYTES / 64 - 1) * 64);
   localparam logic [ADDR_W-1:0] LAST_96  = ADDR_W'((CHUNK_BYTES / 96 - 1) * 96);
   localparam logic [ADDR_W-1:0] LAST_128 = ADDR_W'((CHUNK_BYTES / 128 - 1) * 128);
   localparam logic [ADDR_W-1:0] LAST_160 = ADDR_W'((CHUNK_BYTES / 160 - 1) * 160);
   localparam logic [ADDR_W-1:0] LAST_192 = ADDR_W'((CHUNK_BYTES / 192 - 1) * 192);
   localparam logic [ADDR_W-1:0] LAST_224 = ADDR_W'((CHUNK_BYTES / 224 - 1) * 224);
   localparam logic [ADDR_W-1:0] LAST_256 = ADDR_W'((CHUNK_BYTES / 256 - 1) * 256);
   localparam logic [ADDR_W-1:0] LAST_320 = ADDR_W'((CHUNK_BYTES / 320 - 1) * 320);
   localparam logic [ADDR_W-1:0] LAST_384 = ADDR_W'((CHUNK_BYTES / 384 - 1) * 384);
   localparam logic [ADDR_W-1:0] LAST_448 = ADDR_W'((CHUNK_BYTES / 448 - 1) * 448);
   localparam logic [ADDR_W-1:0] LAST_512 = ADDR_W'((CHUNK_BYTES / 512 - 1) * 512);
   localparam logic [ADDR_W-1:0] LAST_640 = ADDR_W'((CHUNK_BYTES / 640 - 1) * 640);

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_ZERO      = 2'd1;
   localparam logic [1:0] ST_OVERSIZE  = 2'd2;
   localparam logic [1:0] ST_EXHAUSTED = 2'd3;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [15:0]        req_size;
      logic [ADDR_W-1:0]  block_addr;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [ADDR_W-1:0]  alloc_addr;
      logic [CLASS_W-1:0] size_class;
   } rsp_type;

   // classified command between front and back
   typedef struct packed {
      logic [1:0]         opcode;   // OP_NONE also stands for a no-action item
      logic [1:0]         status;
      logic [CLASS_W-1:0] size_class;
      logic [ADDR_W-1:0]  block_addr;
   } cmd_type;

   function automatic logic [BSIZE_W-1:0] class_bytes(input logic [CLASS_W-1:0] c);
      logic [BSIZE_W-1:0] b;
      case (c)
         4'd0:    b = 10'd16;
         4'd1:    b = 10'd32;
         4'd2:    b = 10'd64;
         4'd3:    b = 10'd96;
         4'd4:    b = 10'd128;
         4'd5:    b = 10'd160;
         4'd6:    b = 10'd192;
         4'd7:    b = 10'd224;
         4'd8:    b = 10'd256;
         4'd9:    b = 10'd320;
         4'd10:   b = 10'd384;
         4'd11:   b = 10'd448;
         4'd12:   b = 10'd512;
         default: b = 10'd640;
      endcase
      return b;
   endfunction

   function automatic logic [ADDR_W-1:0] class_last(input logic [CLASS_W-1:0] c);
      logic [ADDR_W-1:0] o;
      case (c)
         4'd0:    o = LAST_16;
         4'd1:    o = LAST_32;
         4'd2:    o = LAST_64;
         4'd3:    o = LAST_96;
         4'd4:    o = LAST_128;
         4'd5:    o = LAST_160;
         4'd6:    o = LAST_192;
         4'd7:    o = LAST_224;
         4'd8:    o = LAST_256;
         4'd9:    o = LAST_320;
         4'd10:   o = LAST_384;
         4'd11:   o = LAST_448;
         4'd12:   o = LAST_512;
         default: o = LAST_640;
      endcase
      return o;
   endfunction
endpackage

@@ src/scba_if.sv @@
// valid/ready channel interfaces
`timescale 1ns / 1ps
interface scba_req_if;
   import scba_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface scba_rsp_if;
   import scba_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ src/scba_front.sv @@
// front: accepts words, classifies size and queues commands
`timescale 1ns / 1ps
module scba_front (
   input  logic              clock,
   input  logic              reset,
   scba_req_if.sink          req,
   output scba_pkg::cmd_type cmd_data,
   output logic              cmd_valid,
   input  logic              cmd_ready
);
   import scba_pkg::*;

   cmd_type               q_ff [QDEPTH];
   logic [$clog2(QDEPTH)-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [$clog2(QDEPTH):0]   cnt_ff, cnt_in;
   cmd_type               cls;
   logic                  push, pop;
   logic [CLASS_W-1:0]    c;

   // class by comparing against every bound but the top one (independent compares)
   always_comb begin
      c = CLASS_W'(CLASS_COUNT - 1);
      for (int i = CLASS_COUNT - 2; i >= 0; i--) begin
         if ({6'd0, req.data.req_size[9:0]} <= {6'd0, class_bytes(CLASS_W'(i))})
            c = CLASS_W'(i);
      end
      cls.opcode     = req.data.opcode;
      cls.status     = ST_OK;
      cls.size_class = '0;
      cls.block_addr = req.data.block_addr;
      if (req.data.opcode == OP_ALLOC || req.data.opcode == OP_FREE) begin
         if (req.data.req_size == 16'd0) begin
            cls.status = ST_ZERO;
            cls.opcode = OP_NONE;
         end else if (req.data.req_size > 16'(MAX_BLOCK)) begin
            cls.status = ST_OVERSIZE;
            cls.opcode = OP_NONE;
         end else begin
            cls.size_class = c;
         end
      end
   end

   assign req.ready = (cnt_ff != ($clog2(QDEPTH)+1)'(QDEPTH));
   assign push      = req.valid && req.ready;
   assign cmd_valid = (cnt_ff != '0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd_data  = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + ($clog2(QDEPTH)+1)'(push) - ($clog2(QDEPTH)+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wp_ff] <= cls;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= ($clog2(QDEPTH)+1)'(QDEPTH)) else $error("queue overflow");
   a_full_block: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == ($clog2(QDEPTH)+1)'(QDEPTH)) |-> !push) else $error("push when full");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0) else $error("pop when empty");
endmodule

@@ src/scba_back.sv @@
// back: free list heads, link memory and chunk carving sequencer
`timescale 1ns / 1ps
module scba_back (
   input  logic              clock,
   input  logic              reset,
   input  scba_pkg::cmd_type cmd_data,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   scba_rsp_if.source        rsp
);
   import scba_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_POP   = 3'd1;
   localparam logic [2:0] S_CARVE = 3'd2;
   localparam logic [2:0] S_OUT   = 3'd3;

   logic [2:0]          state_ff, state_in;
   logic [ADDR_W:0]     heads_ff [CLASS_COUNT];
   logic [CLASS_COUNT-1:0] hvalid_ff;
   logic [CHUNK_W-1:0]  chunks_ff;
   cmd_type             cur_ff;
   rsp_type             out_ff;
   logic                out_valid_ff;
   logic [ADDR_W:0]     mem [2**SLOT_W];
   logic [ADDR_W:0]     rd_ff;
   logic [ADDR_W-1:0]   here_ff;
   logic [ADDR_W-1:0]   last_ff;
   logic [BSIZE_W-1:0]  bsize;
   logic [ADDR_W:0]     head_rd;
   logic [31:0]         base_full;
   logic [ADDR_W-1:0]   next_addr;

   assign bsize     = class_bytes(cur_ff.size_class);
   assign head_rd   = hvalid_ff[cur_ff.size_class] ? heads_ff[cur_ff.size_class] : '0;
   assign base_full = 32'(chunks_ff) * 32'(CHUNK_BYTES);
   assign next_addr = here_ff + ADDR_W'(bsize);
   assign cmd_ready = (state_ff == S_IDLE) && !out_valid_ff;
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (cmd_valid && cmd_ready) state_in = S_OUT;
         S_OUT: begin
            if (cur_ff.opcode == OP_ALLOC && head_rd[ADDR_W]) state_in = S_POP;
            else if (cur_ff.opcode == OP_ALLOC &&
                     chunks_ff < CHUNK_W'(NUM_CHUNKS)) state_in = S_CARVE;
            else state_in = S_IDLE;
         end
         S_POP:   state_in = S_IDLE;
         S_CARVE: if (here_ff == last_ff) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[head_rd[ADDR_W-1:4]];
      if (reset) begin
         state_ff     <= S_IDLE;
         hvalid_ff    <= '0;
         chunks_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp.valid && rsp.ready) out_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (cmd_valid && cmd_ready) cur_ff <= cmd_data;
            S_OUT: begin
               out_ff.size_class <= cur_ff.size_class;
               case (cur_ff.opcode)
                  OP_CLEAR: begin
                     out_ff.status     <= cur_ff.status;
                     out_ff.alloc_addr <= '0;
                     hvalid_ff <= '0;
                     chunks_ff <= '0;
                     out_valid_ff <= 1'b1;
                  end
                  OP_FREE: begin
                     out_ff.status     <= cur_ff.status;
                     out_ff.alloc_addr <= '0;
                     mem[cur_ff.block_addr[ADDR_W-1:4]] <= head_rd;
                     heads_ff[cur_ff.size_class] <= {1'b1, cur_ff.block_addr};
                     hvalid_ff[cur_ff.size_class] <= 1'b1;
                     out_valid_ff <= 1'b1;
                  end
                  OP_ALLOC: begin
                     if (head_rd[ADDR_W]) begin
                        out_ff.status     <= cur_ff.status;
                        out_ff.alloc_addr <= head_rd[ADDR_W-1:0];
                     end else if (chunks_ff < CHUNK_W'(NUM_CHUNKS)) begin
                        out_ff.status     <= cur_ff.status;
                        out_ff.alloc_addr <= base_full[ADDR_W-1:0];
                        here_ff <= base_full[ADDR_W-1:0];
                        last_ff <= base_full[ADDR_W-1:0] + class_last(cur_ff.size_class);
                        chunks_ff <= chunks_ff + 1'b1;
                     end else begin
                        out_ff.status     <= ST_EXHAUSTED;
                        out_ff.alloc_addr <= '0;
                        out_valid_ff <= 1'b1;
                     end
                  end
                  default: begin
                     out_ff.status     <= cur_ff.status;
                     out_ff.alloc_addr <= '0;
                     out_valid_ff <= 1'b1;
                  end
               endcase
            end
            S_POP: begin
               heads_ff[cur_ff.size_class] <= rd_ff;
               out_valid_ff <= 1'b1;
            end
            S_CARVE: begin
               if (here_ff == last_ff) begin
                  mem[here_ff[ADDR_W-1:4]] <= '0;
                  heads_ff[cur_ff.size_class] <=
                     (here_ff == out_ff.alloc_addr) ? '0 : {1'b1, out_ff.alloc_addr + ADDR_W'(bsize)};
                  hvalid_ff[cur_ff.size_class] <= 1'b1;
                  out_valid_ff <= 1'b1;
               end else begin
                  mem[here_ff[ADDR_W-1:4]] <= {1'b1, next_addr};
               end
               here_ff <= next_addr;
            end
            default: ;
         endcase
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_ready |-> state_ff == S_IDLE) else $error("accept while busy");
   a_chunks: assert property (@(posedge clock) disable iff (reset)
      chunks_ff <= CHUNK_W'(NUM_CHUNKS)) else $error("chunk count overrun");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> state_ff == S_IDLE) else $error("result while busy");
endmodule

@@ src/size_class_block_allocator_core.sv @@
// top level of the size class block allocator
`timescale 1ns / 1ps
// Segregated free list allocator over 64 chunks of 16384 bytes. A word on req
// allocates, frees or clears; one word comes back on rsp for each. A front
// stage classifies the size into one of 14 classes and queues the command in
// a two entry queue; the back stage owns the list heads and a 65536 entry
// link memory. A pop from a non-empty list goes through head read, link
// memory read and head update. An allocate that carves a new chunk writes
// one link entry per block. The link memory needs no clearing pass after
// reset.
module size_class_block_allocator_core (
   input logic        clock,
   input logic        reset,
   scba_req_if.sink   req,
   scba_rsp_if.source rsp
);
   import scba_pkg::*;

   cmd_type cmd_data;
   logic    cmd_valid;
   logic    cmd_ready;

   // classify and queue
   scba_front u_front (
      .clock, .reset, .req,
      .cmd_data, .cmd_valid, .cmd_ready
   );

   // list and chunk management
   scba_back u_back (
      .clock, .reset,
      .cmd_data, .cmd_valid, .cmd_ready, .rsp
   );
endmodule

@@ sim/tb_top.sv @@
// testbench for the size class block allocator: queued driver, predictor and checking monitor
`timescale 1ns / 1ps
module tb_top;
   import scba_pkg::*;

   localparam int RAND_ITEMS  = 300;
   localparam int FILL_ITEMS  = 1280;
   localparam int QUIET_TAIL  = 200;
   localparam int DRAIN_WAIT  = 1100;
   localparam int CYCLE_LIMIT = 10000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   scba_req_if req_if ();
   scba_rsp_if rsp_if ();

   size_class_block_allocator_core u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // words waiting to be driven and words still owed by the block
   req_type pending_words[$];
   rsp_type owed_rsps[$];
   int      sent_count = 0;
   int      error_count = 0;
   int      cycle_count = 0;
   bit      stim_done = 1'b0;

   // shadow allocator state
   int unsigned class_size[CLASS_COUNT] =
      '{16, 32, 64, 96, 128, 160, 192, 224, 256, 320, 384, 448, 512, 640};
   logic [ADDR_W:0] shadow_heads[CLASS_COUNT];
   logic [ADDR_W:0] shadow_links[1 << SLOT_W];
   int unsigned     shadow_chunks;

   function automatic logic [SLOT_W-1:0] slot_of(input logic [31:0] a);
      return a[ADDR_W-1:4];
   endfunction

   function automatic int unsigned class_for(input int unsigned sz);
      int unsigned c;
      c = 0;
      while (c < CLASS_COUNT - 1 && sz > class_size[c]) c++;
      return c;
   endfunction

   // works out the response to one accepted request and updates the shadow state
   function void allocate_predict(input req_type w);
      rsp_type     r;
      int unsigned c, bsz, cnt, base;
      r = '0;
      if (w.opcode == OP_CLEAR) begin
         foreach (shadow_heads[i]) shadow_heads[i] = '0;
         shadow_chunks = 0;
      end else if (w.opcode != OP_NONE) begin
         if (w.req_size == 0) begin
            r.status = ST_ZERO;
         end else if (w.req_size > MAX_BLOCK) begin
            r.status = ST_OVERSIZE;
         end else begin
            c = class_for(32'(w.req_size));
            r.size_class = CLASS_W'(c);
            if (w.opcode == OP_FREE) begin
               shadow_links[slot_of(32'(w.block_addr))] = shadow_heads[c];
               shadow_heads[c] = {1'b1, w.block_addr};
            end else if (shadow_heads[c][ADDR_W]) begin
               r.alloc_addr = shadow_heads[c][ADDR_W-1:0];
               shadow_heads[c] = shadow_links[slot_of(32'(r.alloc_addr))];
            end else if (shadow_chunks >= NUM_CHUNKS) begin
               r.status = ST_EXHAUSTED;
            end else begin
               // carve a fresh chunk: block 0 goes out, the rest form the list
               bsz  = class_size[c];
               cnt  = CHUNK_BYTES / bsz;
               base = shadow_chunks * CHUNK_BYTES;
               for (int unsigned i = 0; i + 1 < cnt; i++)
                  shadow_links[slot_of(base + bsz * i)] = {1'b1, 20'(base + bsz * (i + 1))};
               shadow_links[slot_of(base + bsz * (cnt - 1))] = '0;
               r.alloc_addr = base[ADDR_W-1:0];
               shadow_heads[c] = (cnt > 1) ? {1'b1, 20'(base + bsz)} : '0;
               shadow_chunks++;
            end
         end
      end
      owed_rsps.push_back(r);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
   endtask

   function automatic req_type make_word(input int unsigned op, input int unsigned sz,
                                         input int unsigned a);
      req_type w;
      w.opcode = 2'(op);
      w.req_size = 16'(sz);
      w.block_addr = ADDR_W'(a);
      return w;
   endfunction

   // random stimulus: mostly well-formed allocate and free traffic, some noise
   function automatic req_type random_word();
      int unsigned pick, sz, c;
      pick = $urandom_range(0, 99);
      sz = $urandom_range(1, MAX_BLOCK);
      c = class_for(sz);
      if (pick < 48)
         return make_word(OP_ALLOC, sz, $urandom);
      else if (pick < 82)
         // aligned block inside the pool, possibly never handed out
         return make_word(OP_FREE, sz,
            $urandom_range(0, NUM_CHUNKS - 1) * CHUNK_BYTES
            + $urandom_range(0, CHUNK_BYTES / class_size[c] - 1) * class_size[c]);
      else if (pick < 86)
         return make_word(OP_FREE, sz, $urandom);
      else if (pick < 90)
         return make_word($urandom_range(0, 1), 0, $urandom);
      else if (pick < 95)
         return make_word($urandom_range(0, 1), $urandom_range(MAX_BLOCK + 1, 65535), $urandom);
      else if (pick < 97)
         return make_word(OP_NONE, $urandom, $urandom);
      else
         return make_word(OP_CLEAR, $urandom, $urandom);
   endfunction

   // driver: holds valid until the word is taken, idles in short bursts
   int unsigned drive_gap = 0;
   always @(posedge clock) begin
      int unsigned idx;
      bit          quiet;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.data  <= '0;
      end else begin
         idx = sent_count;
         if (req_if.valid && req_if.ready) begin
            allocate_predict(req_if.data);
            idx = sent_count + 1;
            sent_count <= idx;
         end
         quiet = (pending_words.size() - idx) < QUIET_TAIL;
         if (req_if.valid && !req_if.ready) begin
            // word still waiting, keep it up
         end else if (drive_gap > 0) begin
            drive_gap <= drive_gap - 1;
            req_if.valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            drive_gap <= $urandom_range(0, 3);
            req_if.valid <= 1'b0;
         end else if (stim_done && idx < pending_words.size()) begin
            req_if.valid <= 1'b1;
            req_if.data  <= pending_words[idx];
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // monitor: random back-pressure, checks each word against the oldest owed one
   int unsigned stall_left = 0;
   always @(posedge clock) begin
      rsp_type want;
      bit      quiet;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (owed_rsps.size() == 0) begin
               report_mismatch("unexpected word", 32'(rsp_if.data), 32'd0);
            end else begin
               want = owed_rsps.pop_front();
               if (rsp_if.data.status !== want.status)
                  report_mismatch("status", 32'(rsp_if.data.status), 32'(want.status));
               if (rsp_if.data.alloc_addr !== want.alloc_addr)
                  report_mismatch("alloc_addr", 32'(rsp_if.data.alloc_addr),
                                  32'(want.alloc_addr));
               if (rsp_if.data.size_class !== want.size_class)
                  report_mismatch("size_class", 32'(rsp_if.data.size_class),
                                  32'(want.size_class));
            end
         end
         quiet = (pending_words.size() - sent_count) < QUIET_TAIL;
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_if.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 3);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      foreach (shadow_heads[i]) shadow_heads[i] = '0;
      foreach (shadow_links[i]) shadow_links[i] = '0;
      shadow_chunks = 0;

      // directed: size edges, every opcode, no-action cases, foreign address
      pending_words.push_back(make_word(OP_ALLOC, 1, '0));
      pending_words.push_back(make_word(OP_ALLOC, 16, '0));
      pending_words.push_back(make_word(OP_ALLOC, 17, '0));
      pending_words.push_back(make_word(OP_ALLOC, 640, '1));
      pending_words.push_back(make_word(OP_ALLOC, 641, '0));
      pending_words.push_back(make_word(OP_ALLOC, 16'hFFFF, '1));
      pending_words.push_back(make_word(OP_ALLOC, 0, '0));
      pending_words.push_back(make_word(OP_FREE, 0, '1));
      pending_words.push_back(make_word(OP_FREE, 16'hFFFF, '1));
      pending_words.push_back(make_word(OP_NONE, 16'hFFFF, '1));
      pending_words.push_back(make_word(OP_FREE, 5, 20'hFFFFF));
      pending_words.push_back(make_word(OP_FREE, 600, 20'h00007));
      pending_words.push_back(make_word(OP_ALLOC, 5, '0));
      pending_words.push_back(make_word(OP_ALLOC, 600, '0));
      pending_words.push_back(make_word(OP_ALLOC, 600, '0));
      pending_words.push_back(make_word(OP_FREE, 640, 20'h0));
      pending_words.push_back(make_word(OP_ALLOC, 640, '0));
      pending_words.push_back(make_word(OP_CLEAR, '1, '1));
      pending_words.push_back(make_word(OP_ALLOC, 384, '0));

      // one chunk per class, then the largest class until the pool runs dry
      pending_words.push_back(make_word(OP_CLEAR, '0, '0));
      for (int k = 0; k < CLASS_COUNT; k++)
         pending_words.push_back(make_word(OP_ALLOC, class_size[k], '0));
      for (int i = 0; i < FILL_ITEMS; i++)
         pending_words.push_back(make_word(OP_ALLOC, $urandom_range(577, 640), '0));
      pending_words.push_back(make_word(OP_ALLOC, 16, '0));
      pending_words.push_back(make_word(OP_FREE, 16, 20'h4000));
      pending_words.push_back(make_word(OP_ALLOC, 16, '0));
      pending_words.push_back(make_word(OP_CLEAR, '0, '0));

      for (int i = 0; i < RAND_ITEMS; i++)
         pending_words.push_back(random_word());
      stim_done = 1'b1;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (sent_count < pending_words.size() || owed_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && owed_rsps.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

@@ files.f @@
src/scba_pkg.sv
src/scba_if.sv
src/scba_front.sv
src/scba_back.sv
src/size_class_block_allocator_core.sv
sim/tb_top.sv
